/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked assertions that are disabled while reset is applied.
// The enclosing module must have clk_i and rst_ni.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define GBN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GBN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/gbn_pkg.sv */
// ---------------------------------------------------------------------------
// Go-back-N endpoint package
// Beat types, event and action codes, and sequence arithmetic helpers.
// ---------------------------------------------------------------------------
package gbn_pkg;

  localparam int MAX_SEQUENCE    = 7;
  localparam int SEQ_MOD         = MAX_SEQUENCE + 1;
  localparam int SEQ_W           = $clog2(SEQ_MOD);
  localparam int SEQ_W1          = SEQ_W + 1;
  localparam int PACKET_BITS_DEF = 64;
  localparam int MAX_RESULTS     = 8;
  localparam int MAX_RESEND      = MAX_RESULTS - 1;

  localparam logic [SEQ_W-1:0] MAX_SEQ_V = SEQ_W'(MAX_SEQUENCE);

  // Event codes.
  localparam logic [2:0] REQ_PACKET       = 3'd0;
  localparam logic [2:0] REQ_PHY_READY    = 3'd1;
  localparam logic [2:0] REQ_FRAME        = 3'd2;
  localparam logic [2:0] REQ_DATA_TIMEOUT = 3'd3;
  localparam logic [2:0] REQ_ACK_TIMEOUT  = 3'd4;

  // Action codes.
  localparam logic [2:0] ACT_STATUS    = 3'd0;
  localparam logic [2:0] ACT_SEND_DATA = 3'd1;
  localparam logic [2:0] ACT_SEND_ACK  = 3'd2;
  localparam logic [2:0] ACT_DELIVER   = 3'd3;
  localparam logic [2:0] ACT_RELEASE   = 3'd4;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] payload;
    logic        frame_is_data;
    logic [2:0]  frame_seq;
    logic [2:0]  peer_ack;
    logic        crc_ok;
  } req_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  out_seq;
    logic [2:0]  out_ack;
    logic [63:0] out_payload;
    logic [2:0]  release_count;
    logic        network_enable;
    logic        last;
  } res_t;

  typedef struct packed {
    logic             we;
    logic [SEQ_W-1:0] waddr;
    logic [SEQ_W-1:0] raddr;
  } mem_req_t;

  function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
    return (s == MAX_SEQ_V) ? '0 : s + 1'b1;
  endfunction

  // Outgoing ack number: one behind the next expected inbound sequence.
  function automatic logic [SEQ_W-1:0] ack_of(input logic [SEQ_W-1:0] e);
    return (e == '0) ? MAX_SEQ_V : e - 1'b1;
  endfunction

  // True when lo <= x < hi in circular order.
  function automatic logic in_window(input logic [SEQ_W-1:0] lo,
                                     input logic [SEQ_W-1:0] x,
                                     input logic [SEQ_W-1:0] hi);
    return (lo <= x && x < hi) || (hi < lo && lo <= x) || (x < hi && hi < lo);
  endfunction

  // Circular distance from a forward to b.
  function automatic logic [SEQ_W-1:0] seq_dist(input logic [SEQ_W-1:0] a,
                                                input logic [SEQ_W-1:0] b);
    logic [SEQ_W:0] d;
    if (b >= a) begin
      d = {1'b0, b} - {1'b0, a};
    end else begin
      d = {1'b0, b} + SEQ_W1'(SEQ_MOD) - {1'b0, a};
    end
    return SEQ_W'(d);
  endfunction

endpackage

/* hdl/gbn_store.sv */
// ---------------------------------------------------------------------------
// Outbound frame store
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module gbn_store #(
  parameter int PACKET_BITS = gbn_pkg::PACKET_BITS_DEF
) (
  input  logic                   clk_i,
  input  gbn_pkg::mem_req_t      mem_req_i,
  input  logic [PACKET_BITS-1:0] wdata_i,
  output logic [PACKET_BITS-1:0] rdata_o
);
  import gbn_pkg::*;

  logic [PACKET_BITS-1:0] mem [SEQ_MOD];
  logic [PACKET_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem[mem_req_i.waddr] <= wdata_i;
    end
    rdata_q <= mem[mem_req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/gbn_ctrl.sv */
// ---------------------------------------------------------------------------
// Go-back-N event sequencer
// Holds the window state, steps through one event and emits its beats.
// ---------------------------------------------------------------------------
module gbn_ctrl #(
  parameter int PACKET_BITS = gbn_pkg::PACKET_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  gbn_pkg::req_t          req_i,
  output logic                   res_valid_o,
  output gbn_pkg::res_t          res_o,
  output gbn_pkg::mem_req_t      mem_req_o,
  output logic [PACKET_BITS-1:0] wdata_o,
  input  logic [PACKET_BITS-1:0] rdata_i
);
  import gbn_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_REL    = 3'd2;
  localparam logic [2:0] ST_RESEND = 3'd3;
  localparam logic [2:0] ST_STATUS = 3'd4;

  logic [2:0]       state_q, state_d;
  req_t             req_q, req_d;
  logic [SEQ_W-1:0] nts_q, nts_d;
  logic [SEQ_W-1:0] oldest_q, oldest_d;
  logic [SEQ_W-1:0] exp_q, exp_d;
  logic [SEQ_W-1:0] oc_q, oc_d;
  logic [SEQ_W-1:0] rem_q, rem_d;
  logic             link_q, link_d;

  logic [PACKET_BITS-1:0] word;
  logic [SEQ_W-1:0]       fack;
  logic [SEQ_W:0]         rel_n;
  logic [SEQ_W-1:0]       resend_n;
  logic                   deliver;

  assign word     = PACKET_BITS'(req_q.payload);
  assign fack     = SEQ_W'(req_q.peer_ack);
  assign rel_n    = {1'b0, seq_dist(oldest_q, fack)} + 1'b1;
  assign resend_n = (int'(oc_q) > MAX_RESEND) ? SEQ_W'(MAX_RESEND) : oc_q;
  assign deliver  = req_q.frame_is_data && (SEQ_W'(req_q.frame_seq) == exp_q);
  assign wdata_o  = word;
  assign busy     = (state_q != ST_IDLE);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    nts_d       = nts_q;
    oldest_d    = oldest_q;
    exp_d       = exp_q;
    oc_d        = oc_q;
    rem_d       = rem_q;
    link_d      = link_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    mem_req_o   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          req_d   = req_i;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_STATUS;
        unique case (req_q.req_type)
          REQ_PACKET: begin
            if (oc_q < MAX_SEQ_V) begin
              mem_req_o.we      = 1'b1;
              mem_req_o.waddr   = nts_q;
              res_valid_o       = 1'b1;
              res_o.action      = ACT_SEND_DATA;
              res_o.out_seq     = 3'(nts_q);
              res_o.out_ack     = 3'(ack_of(exp_q));
              res_o.out_payload = 64'(word);
              oc_d              = oc_q + 1'b1;
              nts_d             = seq_inc(nts_q);
              link_d            = 1'b0;
            end
          end
          REQ_PHY_READY: begin
            link_d = 1'b1;
          end
          REQ_FRAME: begin
            if (req_q.crc_ok) begin
              if (deliver) begin
                res_valid_o       = 1'b1;
                res_o.action      = ACT_DELIVER;
                res_o.out_payload = 64'(word);
                exp_d             = seq_inc(exp_q);
              end
              state_d = ST_REL;
            end
          end
          REQ_DATA_TIMEOUT: begin
            // Rewind and prefetch the oldest outstanding word.
            nts_d           = oldest_q;
            mem_req_o.raddr = oldest_q;
            rem_d           = resend_n;
            if (resend_n != '0) begin
              state_d = ST_RESEND;
            end
          end
          REQ_ACK_TIMEOUT: begin
            res_valid_o   = 1'b1;
            res_o.action  = ACT_SEND_ACK;
            res_o.out_ack = 3'(ack_of(exp_q));
            link_d        = 1'b0;
          end
          default: begin
          end
        endcase
      end
      ST_REL: begin
        // A cumulative ack releases everything up to and including it.
        if (in_window(oldest_q, fack, nts_q)) begin
          res_valid_o         = 1'b1;
          res_o.action        = ACT_RELEASE;
          res_o.out_seq       = 3'(oldest_q);
          res_o.release_count = 3'(rel_n);
          oldest_d            = seq_inc(fack);
          oc_d                = ({1'b0, oc_q} > rel_n) ? SEQ_W'({1'b0, oc_q} - rel_n) : '0;
        end
        state_d = ST_STATUS;
      end
      ST_RESEND: begin
        // The word for nts_q was read in the previous cycle.
        res_valid_o       = 1'b1;
        res_o.action      = ACT_SEND_DATA;
        res_o.out_seq     = 3'(nts_q);
        res_o.out_ack     = 3'(ack_of(exp_q));
        res_o.out_payload = 64'(rdata_i);
        link_d            = 1'b0;
        nts_d             = seq_inc(nts_q);
        mem_req_o.raddr   = seq_inc(nts_q);
        rem_d             = rem_q - 1'b1;
        if (rem_q == SEQ_W'(1)) begin
          state_d = ST_STATUS;
        end
      end
      ST_STATUS: begin
        res_valid_o          = 1'b1;
        res_o.action         = ACT_STATUS;
        res_o.network_enable = (oc_q < MAX_SEQ_V) && link_q;
        res_o.last           = 1'b1;
        state_d              = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      nts_q    <= '0;
      oldest_q <= '0;
      exp_q    <= '0;
      oc_q     <= '0;
      rem_q    <= '0;
      link_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      nts_q    <= nts_d;
      oldest_q <= oldest_d;
      exp_q    <= exp_d;
      oc_q     <= oc_d;
      rem_q    <= rem_d;
      link_q   <= link_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

endmodule

/* hdl/go_back_n_link_endpoint_unit.sv */
// ---------------------------------------------------------------------------
// Go-back-N link endpoint
// An event steps through accept, execute and status; a good frame adds an ack
// check before status, and a data timeout adds a resend of N frames from the
// store at one per cycle (up to 7). Beats cannot be stalled.
// Reset clears the window state and link flag; the store is not cleared.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module go_back_n_link_endpoint_unit #(
  parameter int PACKET_BITS = gbn_pkg::PACKET_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  gbn_pkg::req_t req_i,
  output logic          res_valid_o,
  output gbn_pkg::res_t res_o
);
  import gbn_pkg::*;

  mem_req_t               mem_req;
  logic [PACKET_BITS-1:0] wdata;
  logic [PACKET_BITS-1:0] rdata;

  gbn_ctrl #(
    .PACKET_BITS(PACKET_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .mem_req_o  (mem_req),
    .wdata_o    (wdata),
    .rdata_i    (rdata)
  );

  gbn_store #(
    .PACKET_BITS(PACKET_BITS)
  ) u_store (
    .clk_i    (clk_i),
    .mem_req_i(mem_req),
    .wdata_i  (wdata),
    .rdata_o  (rdata)
  );

  `GBN_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted event did not raise busy")
  `GBN_ASSERT_NXT(a_last_ends, res_valid_o && res_o.last, !busy, "status beat did not end event")
  `GBN_ASSERT_IMP(a_beat_busy, res_valid_o, busy, "result beat while idle")
  `GBN_ASSERT_IMP(a_enable_status, res_valid_o && !res_o.last, !res_o.network_enable,
                  "network enable on a non-status beat")

endmodule

/* bench/tb_go_back_n_link_endpoint_unit.sv */
// ---------------------------------------------------------------------------
// Go-back-N link endpoint testbench
// Drives link events through the start/busy handshake and predicts every
// result beat with a behavioural copy of the window, inbound sequence and
// outbound frame store. A short directed part covers the corner cases. Random
// traffic follows: mostly well-formed frames and acks that follow the window,
// with some noise and sender gaps of varying density.
// ---------------------------------------------------------------------------
module tb_go_back_n_link_endpoint_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import gbn_pkg::*;

  // Request codes that the block does not use.
  localparam logic [2:0] REQ_SPARE_LO = 3'd5;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;
  // Longest event (a full resend) plus some margin, in cycles.
  localparam int EVENT_LATENCY = 14;

  typedef logic [2:0] seq_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  req_t req_i  = '0;
  logic busy;
  logic res_valid_o;
  res_t res_o;

  go_back_n_link_endpoint_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always #5 clk_i = ~clk_i;

  // Predicted endpoint state.
  seq_t        tx_next     = '0;
  seq_t        tx_base     = '0;
  seq_t        rx_expect   = '0;
  int          tx_inflight = 0;
  logic        phy_ready   = 1'b0;
  logic [63:0] tx_copy [8];

  res_t awaited_beats [$];

  int events_sent   = 0;
  int beats_checked = 0;
  int error_count   = 0;
  int action_seen [8];
  int idle_pct      = 0;
  int calm_left     = 0;

  function automatic res_t make_beat(logic [2:0] act, seq_t seq, seq_t ack,
                                     logic [63:0] word, logic [2:0] cnt,
                                     logic en, logic lst);
    res_t b;
    b.action         = act;
    b.out_seq        = seq;
    b.out_ack        = ack;
    b.out_payload    = word;
    b.release_count  = cnt;
    b.network_enable = en;
    b.last           = lst;
    return b;
  endfunction

  function automatic req_t make_req(logic [2:0] kind, logic [63:0] word,
                                    logic is_data, seq_t seq, seq_t ack,
                                    logic good);
    req_t r;
    r.req_type      = kind;
    r.payload       = word;
    r.frame_is_data = is_data;
    r.frame_seq     = seq;
    r.peer_ack      = ack;
    r.crc_ok        = good;
    return r;
  endfunction

  // Circular lo <= x < hi, measured as offsets from lo.
  function automatic logic seq_within(seq_t lo, seq_t x, seq_t hi);
    seq_t off;
    seq_t span;
    off  = x - lo;
    span = hi - lo;
    return off < span;
  endfunction

  task automatic queue_data_frame(seq_t s);
    awaited_beats.push_back(make_beat(ACT_SEND_DATA, s, rx_expect - 3'd1, tx_copy[s],
                                      3'd0, 1'b0, 1'b0));
    phy_ready = 1'b0;
  endtask

  task automatic forecast_link_event(input req_t r);
    seq_t first;
    int   n;
    int   sent;
    sent = 0;
    case (r.req_type)
      REQ_PACKET: begin
        if (tx_inflight < MAX_SEQUENCE) begin
          tx_copy[tx_next] = r.payload;
          tx_inflight++;
          queue_data_frame(tx_next);
          tx_next++;
        end
      end
      REQ_PHY_READY: phy_ready = 1'b1;
      REQ_FRAME: begin
        if (r.crc_ok) begin
          if (r.frame_is_data && r.frame_seq == rx_expect) begin
            awaited_beats.push_back(make_beat(ACT_DELIVER, '0, '0, r.payload, '0,
                                              1'b0, 1'b0));
            rx_expect++;
          end
          // A cumulative ack releases everything up to and including it.
          first = tx_base;
          n     = 0;
          while (n < 8 && seq_within(tx_base, r.peer_ack, tx_next)) begin
            if (tx_inflight > 0) tx_inflight--;
            tx_base++;
            n++;
          end
          if (n > 0) begin
            awaited_beats.push_back(make_beat(ACT_RELEASE, first, '0, '0, 3'(n),
                                              1'b0, 1'b0));
          end
        end
      end
      REQ_DATA_TIMEOUT: begin
        tx_next = tx_base;
        while (sent < tx_inflight && sent < MAX_RESEND) begin
          queue_data_frame(tx_next);
          tx_next++;
          sent++;
        end
      end
      REQ_ACK_TIMEOUT: begin
        awaited_beats.push_back(make_beat(ACT_SEND_ACK, '0, rx_expect - 3'd1, '0, '0,
                                          1'b0, 1'b0));
        phy_ready = 1'b0;
      end
      default: ;
    endcase
    awaited_beats.push_back(make_beat(ACT_STATUS, '0, '0, '0, '0,
                                      (tx_inflight < MAX_SEQUENCE) && phy_ready, 1'b1));
  endtask

  // Holds the event on the port until the block takes it.
  task automatic send_event(input req_t r);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy !== 1'b0);
    forecast_link_event(r);
    events_sent++;
  endtask

  task automatic hold_off();
    if (calm_left > 0) begin
      calm_left--;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end else if ($urandom_range(0, 19) == 0) begin
      calm_left = $urandom_range(5, 15);
    end
  endtask

  task automatic drain_link();
    start <= 1'b0;
    while (awaited_beats.size() != 0) @(posedge clk_i);
    repeat (EVENT_LATENCY) @(posedge clk_i);
  endtask

  // Mostly well-formed traffic that follows the window, with some noise.
  function automatic req_t random_event();
    req_t r;
    int   pick;
    r.payload       = {$urandom, $urandom};
    r.frame_is_data = 1'($urandom_range(0, 1));
    r.frame_seq     = 3'($urandom_range(0, 7));
    r.peer_ack      = 3'($urandom_range(0, 7));
    r.crc_ok        = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 32) begin
      r.req_type = REQ_PACKET;
    end else if (pick < 46) begin
      r.req_type = REQ_PHY_READY;
    end else if (pick < 78) begin
      r.req_type      = REQ_FRAME;
      r.crc_ok        = ($urandom_range(0, 9) != 0);
      r.frame_is_data = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) != 0) r.frame_seq = rx_expect;
      if (tx_inflight > 0 && $urandom_range(0, 3) != 0) begin
        r.peer_ack = tx_base + 3'($urandom_range(0, tx_inflight - 1));
      end
    end else if (pick < 86) begin
      r.req_type = REQ_DATA_TIMEOUT;
    end else if (pick < 94) begin
      r.req_type = REQ_ACK_TIMEOUT;
    end else if (pick < 97) begin
      r.req_type = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
    end else begin
      r.req_type = REQ_FRAME;
    end
    return r;
  endfunction

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_valid_o === 1'b1) begin
      beats_checked++;
      if (awaited_beats.size() == 0) begin
        error_count++;
        $display("%0t: result beat with nothing expected: expected none got %p",
                 $time, res_o);
      end else begin
        want = awaited_beats.pop_front();
        action_seen[res_o.action]++;
        compare_field("action", want.action, res_o.action);
        compare_field("out_seq", want.out_seq, res_o.out_seq);
        compare_field("out_ack", want.out_ack, res_o.out_ack);
        compare_field("out_payload", want.out_payload, res_o.out_payload);
        compare_field("release_count", want.release_count, res_o.release_count);
        compare_field("network_enable", want.network_enable, res_o.network_enable);
        compare_field("last", want.last, res_o.last);
      end
    end
  end

  // Unused codes and a bare ack on an idle link, then the link comes up.
  task automatic test_quiet_link();
    for (int code = REQ_SPARE_LO; code <= REQ_SPARE_HI; code++) begin
      send_event(make_req(3'(code), '1, 1'b1, 3'd7, 3'd7, 1'b1));
    end
    send_event(make_req(REQ_ACK_TIMEOUT, '1, 1'b1, 3'd7, 3'd7, 1'b1));
    send_event(make_req(REQ_PHY_READY, '0, 1'b0, 3'd0, 3'd0, 1'b0));
  endtask

  // Fill the window, offer one packet too many, then resend all of it.
  task automatic test_window_limits();
    logic [63:0] words [4] = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0,
                               64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555};
    logic [63:0] w;
    for (int i = 0; i < 8; i++) begin
      w = (i < 4) ? words[i] : {$urandom, $urandom};
      send_event(make_req(REQ_PACKET, w, 1'b0, 3'd0, 3'd0, 1'b0));
    end
    send_event(make_req(REQ_DATA_TIMEOUT, '0, 1'b0, 3'd0, 3'd0, 1'b0));
  endtask

  task automatic test_frame_cases();
    // Bad CRC hides an ack that would otherwise release frames.
    send_event(make_req(REQ_FRAME, {$urandom, $urandom}, 1'b1, 3'd0, 3'd3, 1'b0));
    // Out of order, and its ack lies outside the window.
    send_event(make_req(REQ_FRAME, {$urandom, $urandom}, 1'b1, 3'd5, 3'd7, 1'b1));
    send_event(make_req(REQ_FRAME, '1, 1'b1, 3'd0, 3'd2, 1'b1));
    // A bare ack frame carries the ack but delivers nothing.
    send_event(make_req(REQ_FRAME, '1, 1'b0, 3'd1, 3'd6, 1'b1));
    // Nothing outstanding: the timeout resends nothing.
    send_event(make_req(REQ_DATA_TIMEOUT, '0, 1'b0, 3'd0, 3'd0, 1'b0));
    send_event(make_req(REQ_PHY_READY, '0, 1'b0, 3'd0, 3'd0, 1'b0));
  endtask

  task automatic test_random_traffic(int count, int gap_pct);
    idle_pct  = gap_pct;
    calm_left = 0;
    for (int i = 0; i < count; i++) begin
      send_event(random_event());
      hold_off();
    end
  endtask

  initial begin
    int guard;
    guard = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_quiet_link();
    test_window_limits();
    test_frame_cases();
    drain_link();
    test_random_traffic(120, 0);
    drain_link();
    test_random_traffic(115, 72);
    drain_link();
    test_random_traffic(115, 19);

    start <= 1'b0;
    while (awaited_beats.size() != 0 && guard < 4000) begin
      @(posedge clk_i);
      guard++;
    end
    if (awaited_beats.size() != 0) begin
      error_count += awaited_beats.size();
      $display("%0t: %0d expected result beats never arrived", $time,
               awaited_beats.size());
    end
    repeat (EVENT_LATENCY) @(posedge clk_i);

    $display("Drove %0d link events: corner cases, then random traffic with sender gaps",
             events_sent);
    $display("Checked %0d beats: %0d data, %0d ack, %0d deliver, %0d release, %0d status",
             beats_checked, action_seen[ACT_SEND_DATA], action_seen[ACT_SEND_ACK],
             action_seen[ACT_DELIVER], action_seen[ACT_RELEASE], action_seen[ACT_STATUS]);
    if (error_count == 0) begin
      $display("go_back_n_link_endpoint_unit: match");
    end else begin
      $display("go_back_n_link_endpoint_unit: mismatch");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("go_back_n_link_endpoint_unit: mismatch");
    $finish;
  end

endmodule
